// ----- hdl/ktcl_pkg.sv -----
// ----------------------------------------------------------------------------
// ktcl_pkg
// Shared types, constants and helpers for the keypad time-code lock.
// ----------------------------------------------------------------------------
package ktcl_pkg;

  localparam int unsigned ENTRY_MAX  = 15;
  localparam int unsigned KEY_COUNT  = 12;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned DIV_STEPS  = 33;
  localparam int unsigned DIV_CNT_W  = 6;

  localparam logic [3:0]  KEY_OK     = 4'd9;
  localparam logic [3:0]  KEY_CLR    = 4'd11;
  localparam logic [31:0] NO_SEED    = 32'hFFFF_FFFF;
  localparam logic [7:0]  UNLOCK_RST = 8'd9;
  localparam logic [6:0]  DIV_BY     = 7'd60;
  localparam logic [31:0] HASH_MUL_A = 32'd654;
  localparam logic [31:0] HASH_MUL_B = 32'd54323;

  localparam logic CFG_STORED_SEED = 1'b0;
  localparam logic CFG_UNLOCK_SECS = 1'b1;

  typedef enum logic [1:0] {
    M_SEED   = 2'd0,
    M_LOCKED = 2'd1,
    M_OPEN   = 2'd2
  } ktcl_mode_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DIGIT   = 3'd1,
    EV_BAD     = 3'd2,
    EV_OPENED  = 3'd3,
    EV_RELOCK  = 3'd4,
    EV_SEED    = 3'd5,
    EV_CLEARED = 3'd6
  } ktcl_event_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_HASH,
    C_PUT
  } ktcl_ctl_e;

  typedef enum logic [2:0] {
    H_IDLE,
    H_DIV,
    H_M1,
    H_M2,
    H_M3,
    H_DONE
  } ktcl_hash_e;

  typedef struct packed {
    logic        start;
    logic [31:0] now;
    logic [31:0] seed;
  } ktcl_hash_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] code;
  } ktcl_hash_rsp_t;

  typedef struct packed {
    logic [7:0]  left;
    logic [31:0] seed_out;
    ktcl_mode_e  mode;
    logic [3:0]  echo;
    ktcl_event_e ev;
  } ktcl_res_t;

  function automatic logic [3:0] key_digit(input logic [3:0] k);
    logic [3:0] d;
    unique case (k)
      4'd0:    d = 4'd3;
      4'd1:    d = 4'd2;
      4'd2:    d = 4'd1;
      4'd3:    d = 4'd6;
      4'd4:    d = 4'd5;
      4'd5:    d = 4'd4;
      4'd6:    d = 4'd9;
      4'd7:    d = 4'd8;
      4'd8:    d = 4'd7;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

  function automatic logic [15:0] fold16(input logic [31:0] n);
    return n[15:0] ^ n[31:16];
  endfunction

  function automatic logic [3:0] nib_mod10(input logic [3:0] n);
    return (n >= 4'd10) ? n - 4'd10 : n;
  endfunction

endpackage

// ----- hdl/ktcl_div60.sv -----
// ----------------------------------------------------------------------------
// ktcl_div60
// Restoring divider by sixty, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ktcl_div60 import ktcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [32:0]          dq_q, dq_d;
  logic [5:0]           rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [6:0]           part;
  logic                 ge;

  assign part   = {rem_q, dq_q[32]};
  assign ge     = part >= DIV_BY;
  assign done_o = busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS));
  assign quot_o = dq_q[31:0];

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == DIV_CNT_W'(DIV_STEPS)) begin
        busy_d = 1'b0;
      end else begin
        rem_d = ge ? 6'(part - DIV_BY) : part[5:0];
        dq_d  = {dq_q[31:0], ge};
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
  end

endmodule

// ----- hdl/ktcl_smul.sv -----
// ----------------------------------------------------------------------------
// ktcl_smul
// Shift-add multiplier modulo 2^32, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ktcl_smul import ktcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] prod_o
);

  logic [31:0] a_q, a_d, b_q, b_d, p_q, p_d;
  logic        busy_q, busy_d;

  assign done_o = busy_q && (b_q == '0);
  assign prod_o = p_q;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    busy_d = busy_q;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      p_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (b_q[0]) begin
          p_d = p_q + a_q;
        end
        a_d = {a_q[30:0], 1'b0};
        b_d = {1'b0, b_q[31:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      b_q    <= '0;
    end else begin
      busy_q <= busy_d;
      b_q    <= b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

endmodule

// ----- hdl/ktcl_hash.sv -----
// ----------------------------------------------------------------------------
// ktcl_hash
// Sequencer for the time code: divide by sixty, three folded products,
// each nibble reduced to a decimal digit.
// ----------------------------------------------------------------------------
module ktcl_hash import ktcl_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ktcl_hash_req_t req_i,
  output ktcl_hash_rsp_t rsp_o
);

  ktcl_hash_e  state_q, state_d;
  logic [15:0] fa_q, fa_d;
  logic [15:0] code_q, code_d;
  logic        div_start, div_done;
  logic [31:0] quot;
  logic        mul_start, mul_done;
  logic [31:0] mul_a, mul_b, prod;
  logic [15:0] pf;

  ktcl_div60 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({1'b0, req_i.now} + {1'b0, req_i.seed}),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  ktcl_smul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign pf = fold16(prod);

  always_comb begin
    state_d   = state_q;
    fa_d      = fa_q;
    code_d    = code_q;
    div_start = 1'b0;
    mul_start = 1'b0;
    mul_a     = quot;
    mul_b     = HASH_MUL_A;
    unique case (state_q)
      H_IDLE: begin
        if (req_i.start) begin
          div_start = 1'b1;
          state_d   = H_DIV;
        end
      end
      H_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_d   = H_M1;
        end
      end
      H_M1: begin
        mul_b = HASH_MUL_B;
        if (mul_done) begin
          fa_d      = pf;
          mul_start = 1'b1;
          state_d   = H_M2;
        end
      end
      H_M2: begin
        mul_a = {16'd0, fa_q};
        mul_b = {16'd0, pf};
        if (mul_done) begin
          mul_start = 1'b1;
          state_d   = H_M3;
        end
      end
      H_M3: begin
        if (mul_done) begin
          code_d  = {nib_mod10(pf[15:12]), nib_mod10(pf[11:8]),
                     nib_mod10(pf[7:4]), nib_mod10(pf[3:0])};
          state_d = H_DONE;
        end
      end
      H_DONE: begin
        state_d = H_IDLE;
      end
      default: begin
        state_d = H_IDLE;
      end
    endcase
  end

  assign rsp_o.done = (state_q == H_DONE);
  assign rsp_o.code = code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fa_q   <= fa_d;
    code_q <= code_d;
  end

endmodule

// ----- hdl/keypad_time_code_lock.sv -----
// a scan that needs no code check is held in the result register, then in the output register
// a four-digit OK in locked mode first waits for the code check, paced by the serial divider
//   (one quotient bit per cycle, 33 bits) and the shift-add multiplier (one bit per cycle)
// scans: one at a time; the next is taken once
//   the result has moved into the output register
// reset: seed entry mode, seed zero, unlock time 9 s, no keys held, no entry, output empty
// ----------------------------------------------------------------------------
// keypad_time_code_lock
// Keypad lock opened by a time-dependent four-digit code derived from a seed.
// ----------------------------------------------------------------------------
module keypad_time_code_lock import ktcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // key_index[3:0], now_seconds[35:4], zero pad
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // event_res[2:0], echo_digit[6:3], mode_now[8:7],
                                      // door_open[9], seed_out[41:10], seconds_left[49:42]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  ktcl_ctl_e      ctl_q, ctl_d;
  ktcl_mode_e     mode_q, mode_d;
  logic [KEY_COUNT-1:0] held_q, held_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [15:0]    code_q, code_d;
  logic [31:0]    seed_q, seed_d;
  logic [31:0]    deadline_q, deadline_d;
  logic [7:0]     unlock_q, unlock_d;
  logic [31:0]    now_q, now_d;
  ktcl_res_t      res_q, res_d;
  ktcl_res_t      out_q;
  logic           mvalid_q;
  ktcl_hash_req_t hreq;
  ktcl_hash_rsp_t hrsp;

  logic        s_accept, out_free, kind;
  logic [3:0]  key, dg;
  logic [31:0] now, dleft, seed_x10;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (ctl_q == C_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !mvalid_q || m_axis_tready;
  assign kind          = s_axis_tuser;
  assign key           = s_axis_tdata[3:0];
  assign now           = s_axis_tdata[35:4];
  assign dg            = key_digit(key);
  assign dleft         = deadline_q - now;
  assign seed_x10      = {seed_q[28:0], 3'b000} + {seed_q[30:0], 1'b0} + {28'd0, dg};

  ktcl_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .rsp_o  (hrsp)
  );

  always_comb begin
    ctl_d      = ctl_q;
    mode_d     = mode_q;
    held_d     = held_q;
    len_d      = len_q;
    code_d     = code_q;
    seed_d     = seed_q;
    deadline_d = deadline_q;
    unlock_d   = unlock_q;
    now_d      = now_q;
    res_d      = res_q;
    hreq.start = 1'b0;
    hreq.now   = now;
    hreq.seed  = seed_q;
    unique case (ctl_q)
      C_IDLE: begin
        if (s_axis_tvalid) begin
          res_d.ev       = EV_NONE;
          res_d.echo     = '0;
          res_d.seed_out = '0;
          res_d.left     = '0;
          ctl_d          = C_PUT;
          now_d          = now;
          if (mode_q == M_OPEN) begin
            if (dleft == '0 || dleft[31]) begin
              mode_d   = M_LOCKED;
              len_d    = '0;
              res_d.ev = EV_RELOCK;
            end else begin
              res_d.left = (|dleft[31:8]) ? 8'hFF : dleft[7:0];
            end
          end else if (!kind) begin
            held_d = '0;
          end else if (key < 4'(KEY_COUNT) && !held_q[key]) begin
            held_d[key] = 1'b1;
            if (key == KEY_CLR) begin
              len_d = '0;
              if (mode_q == M_SEED) begin
                seed_d = '0;
              end
              res_d.ev = EV_CLEARED;
            end else if (key == KEY_OK) begin
              len_d = '0;
              if (mode_q == M_SEED) begin
                mode_d         = M_LOCKED;
                res_d.seed_out = seed_q;
                res_d.ev       = EV_SEED;
              end else if (len_q == LEN_W'(4)) begin
                hreq.start = 1'b1;
                ctl_d      = C_HASH;
              end else begin
                res_d.ev = EV_BAD;
              end
            end else if (len_q < LEN_W'(ENTRY_MAX)) begin
              if (len_q < LEN_W'(4)) begin
                code_d = {((len_q == '0) ? 12'd0 : code_q[11:0]), dg};
              end
              if (mode_q == M_SEED) begin
                seed_d = seed_x10;
              end
              len_d      = len_q + 1'b1;
              res_d.ev   = EV_DIGIT;
              res_d.echo = dg;
            end
          end
          res_d.mode = mode_d;
        end
      end
      C_HASH: begin
        if (hrsp.done) begin
          if (hrsp.code == code_q) begin
            mode_d     = M_OPEN;
            deadline_d = now_q + {24'd0, unlock_q};
            res_d.left = unlock_q;
            res_d.ev   = EV_OPENED;
          end else begin
            res_d.ev = EV_BAD;
          end
          res_d.mode = mode_d;
          ctl_d      = C_PUT;
        end
      end
      C_PUT: begin
        if (out_free) begin
          ctl_d = C_IDLE;
        end
      end
      default: begin
        ctl_d = C_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_STORED_SEED) begin
        if (cfg_data_i != NO_SEED) begin
          seed_d = cfg_data_i;
          mode_d = M_LOCKED;
          len_d  = '0;
        end
      end else if (cfg_index_i == CFG_UNLOCK_SECS) begin
        unlock_d = cfg_data_i[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q      <= C_IDLE;
      mode_q     <= M_SEED;
      held_q     <= '0;
      len_q      <= '0;
      code_q     <= '0;
      seed_q     <= '0;
      deadline_q <= '0;
      unlock_q   <= UNLOCK_RST;
      mvalid_q   <= 1'b0;
    end else begin
      ctl_q      <= ctl_d;
      mode_q     <= mode_d;
      held_q     <= held_d;
      len_q      <= len_d;
      code_q     <= code_d;
      seed_q     <= seed_d;
      deadline_q <= deadline_d;
      unlock_q   <= unlock_d;
      if (ctl_q == C_PUT && out_free) begin
        mvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        mvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    res_q <= res_d;
    if (ctl_q == C_PUT && out_free) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {6'd0, out_q.left, out_q.seed_out, (out_q.mode == M_OPEN),
                          out_q.mode, out_q.echo, out_q.ev};

  // hash result only arrives while a code check is pending
  a_hash_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hrsp.done |-> ctl_q == C_HASH)
    else $error("hash result outside code check");

  // an accepted scan always leaves the idle state
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> ctl_q != C_IDLE)
    else $error("scan accepted without processing");

  // the lock is never open with a partial entry
  a_open_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_OPEN |-> len_q == '0)
    else $error("entry pending while unlocked");

  // seconds left only reported while unlocked
  a_left_only_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.mode != M_OPEN) |-> out_q.left == '0)
    else $error("open time reported while not unlocked");

endmodule

// ----- sim/tb_keypad_time_code_lock.sv -----
// ----------------------------------------------------------------------------
// tb_keypad_time_code_lock
// Self-checking bench for the keypad time-code lock: keypad scans go in over
// the input stream with random gaps, results come back under random stalls and
// are compared field by field with a scan-level model of the lock. The scans
// follow the lock's mode: seed entry, code entry with right and wrong codes,
// open-door countdown with clock jumps, plus some noise.
// ----------------------------------------------------------------------------
module tb_keypad_time_code_lock;
  import ktcl_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned CFG_EVERY    = 250;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;

  // digit of key k at [4k+3:4k], key of digit d at [4d+3:4d]
  localparam logic [47:0] KEY_DIGITS = {4'd0, 4'd0, 4'd0, 4'd7, 4'd8, 4'd9,
                                        4'd4, 4'd5, 4'd6, 4'd1, 4'd2, 4'd3};
  localparam logic [39:0] DIGIT_KEYS = {4'd6, 4'd7, 4'd8, 4'd3, 4'd4,
                                        4'd5, 4'd0, 4'd1, 4'd2, 4'd10};

  typedef struct packed {
    logic        kind;
    logic [3:0]  key;
    logic [31:0] now;
  } scan_t;

  typedef struct packed {
    ktcl_event_e ev;
    logic [3:0]  echo;
    ktcl_mode_e  mode;
    logic        door;
    logic [31:0] seed_out;
    logic [7:0]  left;
  } lock_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_STORED_SEED;
  logic [31:0] cfg_data_i = '0;

  keypad_time_code_lock dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  scan_t        keypad_scans[$];
  lock_result_t due_results[$];
  scan_t        next_scan;
  int unsigned  sent_cnt = 0;
  int unsigned  taken_cnt = 0;
  int unsigned  noise_cnt = 0;
  int unsigned  errors = 0;
  int unsigned  cycle_cnt = 0;
  int           send_wait = 0;
  int           send_calm = 0;
  int           recv_wait = 0;
  int           recv_calm = 0;
  int           stall = 0;
  logic [31:0]  rtc_now = '0;

  // lock state as seen after the last accepted scan
  ktcl_mode_e   lock_mode = M_SEED;
  logic [11:0]  held_keys = '0;
  logic [3:0]   entry_len = '0;
  logic [15:0]  entry_code = '0;
  logic [31:0]  code_seed = '0;
  logic [31:0]  open_until = '0;
  logic [7:0]   open_secs = UNLOCK_RST;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] lock_code(input logic [31:0] now, input logic [31:0] seed);
    logic [32:0] sum;
    logic [32:0] quot;
    logic [31:0] p;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] h;
    logic [15:0] code;
    sum  = {1'b0, now} + {1'b0, seed};
    quot = sum / DIV_BY;
    p = quot[31:0] * HASH_MUL_A;
    a = p[15:0] ^ p[31:16];
    p = quot[31:0] * HASH_MUL_B;
    b = p[15:0] ^ p[31:16];
    p = {16'h0, a} * {16'h0, b};
    h = p[15:0] ^ p[31:16];
    for (int i = 0; i < 4; i++) begin
      code[4*i +: 4] = (h[4*i +: 4] >= 4'd10) ? h[4*i +: 4] - 4'd10 : h[4*i +: 4];
    end
    return code;
  endfunction

  function automatic void apply_scan(input logic kind, input logic [3:0] key,
                                     input logic [31:0] now);
    lock_result_t r;
    logic [31:0]  d;
    logic [3:0]   dg;
    r = '0;
    r.ev = EV_NONE;
    if (lock_mode == M_OPEN) begin
      d = open_until - now;
      if (d == 32'd0 || d[31]) begin
        lock_mode = M_LOCKED;
        entry_len = '0;
        r.ev = EV_RELOCK;
      end else begin
        r.left = (d > 32'd255) ? 8'hFF : d[7:0];
      end
    end else if (!kind) begin
      held_keys = '0;
    end else if (key < KEY_COUNT && !held_keys[key]) begin
      held_keys[key] = 1'b1;
      if (key == KEY_CLR) begin
        entry_len = '0;
        if (lock_mode == M_SEED) code_seed = '0;
        r.ev = EV_CLEARED;
      end else if (key == KEY_OK) begin
        if (lock_mode == M_SEED) begin
          lock_mode = M_LOCKED;
          r.seed_out = code_seed;
          r.ev = EV_SEED;
        end else if (entry_len == 4'd4 && entry_code == lock_code(now, code_seed)) begin
          lock_mode = M_OPEN;
          open_until = now + {24'h0, open_secs};
          r.left = open_secs;
          r.ev = EV_OPENED;
        end else begin
          r.ev = EV_BAD;
        end
        entry_len = '0;
      end else if (entry_len < ENTRY_MAX) begin
        dg = KEY_DIGITS[{key, 2'b00} +: 4];
        if (entry_len < 4'd4)
          entry_code = (entry_len == 4'd0) ? {12'h000, dg} : {entry_code[11:0], dg};
        if (lock_mode == M_SEED) code_seed = code_seed * 32'd10 + {28'h0, dg};
        entry_len = entry_len + 4'd1;
        r.ev = EV_DIGIT;
        r.echo = dg;
      end
    end
    r.mode = lock_mode;
    r.door = (lock_mode == M_OPEN);
    if (lock_mode != M_OPEN) r.left = '0;
    due_results.push_back(r);
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(input logic [55:0] data);
    lock_result_t want;
    if (due_results.size() == 0) begin
      $error("result with nothing expected: %h", data);
      errors++;
      return;
    end
    want = due_results.pop_front();
    compare_field("event_res", {29'h0, want.ev}, {29'h0, data[2:0]});
    compare_field("echo_digit", {28'h0, want.echo}, {28'h0, data[6:3]});
    compare_field("mode_now", {30'h0, want.mode}, {30'h0, data[8:7]});
    compare_field("door_open", {31'h0, want.door}, {31'h0, data[9]});
    compare_field("seed_out", want.seed_out, data[41:10]);
    compare_field("seconds_left", {24'h0, want.left}, {24'h0, data[49:42]});
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [3:0] rand_key(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(lo, hi);
    return r[3:0];
  endfunction

  function automatic logic [3:0] digit_key();
    logic [3:0] k;
    k = rand_key(0, 9);
    return (k == 4'd9) ? 4'd10 : k;
  endfunction

  function automatic logic [31:0] tick();
    rtc_now = rtc_now + $urandom_range(0, 2);
    return rtc_now;
  endfunction

  task automatic push_scan(input logic kind, input logic [3:0] key, input logic [31:0] now);
    scan_t s;
    s.kind = kind;
    s.key  = key;
    s.now  = now;
    keypad_scans.push_back(s);
    sent_cnt++;
  endtask

  task automatic press(input logic [3:0] key, input logic [31:0] now);
    push_scan(1'b0, rand_key(0, 15), now);
    push_scan(1'b1, key, now);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_STORED_SEED) begin
      if (val != NO_SEED) begin
        code_seed = val;
        lock_mode = M_LOCKED;
        entry_len = '0;
      end
    end else begin
      open_secs = val[7:0];
    end
    @(posedge clk_i);
  endtask

  task automatic reconfigure();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0:       v = 32'd1;
      1:       v = 32'd255;
      2:       v = $urandom_range(1, 12);
      default: v = $urandom_range(1, 255);
    endcase
    write_reg(CFG_UNLOCK_SECS, v);
    case ($urandom_range(0, 4))
      0:       v = NO_SEED;
      1:       v = 32'h0;
      2:       v = 32'hFFFF_FFFE;
      default: v = $urandom;
    endcase
    write_reg(CFG_STORED_SEED, v);
  endtask

  task automatic enter_seed();
    int unsigned n;
    int unsigned r;
    n = $urandom_range(0, 18);
    repeat (n) begin
      r = $urandom_range(0, 11);
      if (r == 0) press(KEY_CLR, tick());
      else if (r == 1) push_scan(1'b1, digit_key(), rtc_now);
      else press(digit_key(), tick());
    end
    if ($urandom_range(0, 1)) press(KEY_OK, tick());
  endtask

  task automatic enter_code();
    logic [31:0] t_ok;
    logic [15:0] want;
    int unsigned pick;
    int unsigned k;
    int unsigned nib;
    int unsigned n;
    if (entry_len != 0) press(KEY_CLR, rtc_now);
    t_ok = rtc_now + $urandom_range(0, 40);
    want = lock_code(t_ok, code_seed);
    pick = $urandom_range(0, 9);
    if (pick == 7) begin
      n = $urandom_range(0, 17);
      repeat (n) press(digit_key(), tick());
    end else begin
      if (pick == 6) begin
        k = $urandom_range(0, 3);
        nib = {28'h0, want[4*k +: 4]};
        nib = (nib + $urandom_range(1, 9)) % 10;
        want[4*k +: 4] = nib[3:0];
      end
      for (int i = 3; i >= 0; i--) begin
        press(DIGIT_KEYS[{want[4*i +: 4], 2'b00} +: 4], tick());
        if (pick == 9 && $urandom_range(0, 1))
          push_scan(1'b1, DIGIT_KEYS[{want[4*i +: 4], 2'b00} +: 4], rtc_now);
        if (pick == 9 && $urandom_range(0, 1))
          push_scan(1'b1, rand_key(12, 15), rtc_now);
      end
    end
    if (pick == 8) t_ok = t_ok + 32'd60 * $urandom_range(1, 3);
    press(KEY_OK, t_ok);
    rtc_now = t_ok;
  endtask

  task automatic ride_open();
    logic [31:0] d;
    int unsigned r;
    int unsigned n;
    bit          still_open;
    still_open = 1'b1;
    n = 0;
    while (still_open && n < 40) begin
      d = open_until - rtc_now;
      r = $urandom_range(0, 29);
      if (r == 0) rtc_now = rtc_now - $urandom_range(300, 100000);
      else if (r == 1) rtc_now = $urandom;
      else if (!d[31] && d > 32'd30) rtc_now = rtc_now + $urandom_range(0, d / 8);
      else rtc_now = rtc_now + $urandom_range(0, 3);
      push_scan(1'($urandom_range(0, 1)), rand_key(0, 15), rtc_now);
      d = open_until - rtc_now;
      still_open = !(d == 32'd0 || d[31]);
      n++;
    end
    if (still_open) begin
      rtc_now = open_until;
      push_scan(1'b1, rand_key(0, 15), rtc_now);
    end
  endtask

  // scan driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_wait <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_wait != 0) begin
        s_axis_tvalid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (keypad_scans.size() != 0) begin
        next_scan = keypad_scans.pop_front();
        s_axis_tdata  <= {4'h0, next_scan.now, next_scan.key};
        s_axis_tuser  <= next_scan.kind;
        s_axis_tvalid <= 1'b1;
        send_wait <= draw_wait(send_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // accepted scans feed the model, results are checked against it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_scan(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[35:4]);
        taken_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
        stall = draw_wait(recv_calm);
        m_axis_tready <= (stall == 0);
        recv_wait <= (stall == 0) ? 0 : stall - 1;
      end else if (recv_wait != 0) begin
        m_axis_tready <= 1'b0;
        recv_wait <= recv_wait - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] code;
    logic [31:0] t;
    int unsigned random_start;
    int unsigned next_cfg;
    int unsigned r;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(CFG_STORED_SEED, NO_SEED);
    write_reg(CFG_UNLOCK_SECS, {24'h0, UNLOCK_RST});

    // seed entry: held key, ignored key, clear, then store
    push_scan(1'b0, 4'd0, 32'h0);
    push_scan(1'b1, 4'd15, 32'hFFFF_FFFF);
    push_scan(1'b1, 4'd6, 32'd1);
    push_scan(1'b1, 4'd6, 32'd2);
    push_scan(1'b0, 4'd15, 32'd3);
    push_scan(1'b1, KEY_CLR, 32'd4);
    press(4'd8, 32'd6);
    press(KEY_OK, 32'd8);
    // OK with an empty entry
    press(KEY_OK, 32'd10);
    wait (taken_cnt == sent_cnt);
    // right code close to the clock wrap, deadline wraps too
    t = 32'hFFFF_FFFA;
    code = lock_code(t, code_seed);
    for (int i = 3; i >= 0; i--) press(DIGIT_KEYS[{code[4*i +: 4], 2'b00} +: 4], t);
    press(KEY_OK, t);
    push_scan(1'b1, 4'd3, t + 32'd3);
    push_scan(1'b0, 4'd0, 32'd3);
    push_scan(1'b1, 4'd14, 32'd3);
    rtc_now = 32'd3;

    random_start = sent_cnt;
    next_cfg = sent_cnt + CFG_EVERY;
    while (sent_cnt - noise_cnt - random_start < RANDOM_ITEMS) begin
      wait (taken_cnt == sent_cnt);
      if (sent_cnt >= next_cfg) begin
        wait (due_results.size() == 0);
        @(posedge clk_i);
        reconfigure();
        next_cfg = sent_cnt + CFG_EVERY;
      end
      r = $urandom_range(0, 49);
      if (r == 0) rtc_now = $urandom;
      else if (r == 1) rtc_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(1, 5);
        repeat (r) begin
          push_scan(1'($urandom_range(0, 1)), rand_key(0, 15),
                    $urandom_range(0, 1) ? $urandom : rtc_now);
          noise_cnt++;
        end
      end else begin
        case (lock_mode)
          M_SEED:   enter_seed();
          M_LOCKED: enter_code();
          default:  ride_open();
        endcase
      end
    end

    wait (taken_cnt == sent_cnt);
    wait (due_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
